[rtl/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg
// shared widths, constants and types of the rgb to hsl converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 15;
    localparam int UNIT_W    = 16;

    // divider: numerator / 8-bit divisor, quotient known to fit in QUO_W bits
    localparam int DEN_W     = 8;
    localparam int QUO_W     = 16;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int DIV_STEPS = QUO_W;

    // stage a, stage b, divider steps, stage c
    localparam int N_STAGES  = DIV_STEPS + 3;

    localparam int HUE_SIXTH = 3840;
    localparam int HUE_FULL  = 23040;
    localparam int HUE_Q_W   = 12;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        t_sector                sector;
        logic                   neg;
        logic                   grey;
        logic [UNIT_W-1:0]      lig;
        logic [CHAN_W-1:0]      alpha;
    } t_side;

    typedef struct packed {
        logic [HUE_W-1:0]       hue;
        logic                   undef;
        logic [UNIT_W-1:0]      sat;
        logic [UNIT_W-1:0]      lig;
        logic [CHAN_W-1:0]      alpha;
    } t_result;

endpackage

`default_nettype wire

[rtl/rhc_if.sv]
// ----------------------------------------------------------------------------
// rhc_if
// pixel and hsl item channels, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_pix_if;
    import rhc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface rhc_hsl_if;
    import rhc_pkg::*;

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue_out;
    logic              hue_unset;
    logic [UNIT_W-1:0] saturation_out;
    logic [UNIT_W-1:0] lightness_out;
    logic [CHAN_W-1:0] alpha_out;

    modport source (output valid, output hue_out, output hue_unset,
                    output saturation_out, output lightness_out, output alpha_out,
                    input ready);
    modport sink   (input valid, input hue_out, input hue_unset,
                    input saturation_out, input lightness_out, input alpha_out,
                    output ready);
endinterface

`default_nettype wire

[rtl/rgb_to_hsl_convert.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert
// pixel stream converter from 8-bit rgb to hue, saturation and lightness
// ----------------------------------------------------------------------------
// i_pix carries one pixel per item (red, green, blue, alpha); o_hsl carries
// one result item per pixel, in order: hue in 1/64 degree, an undefined-hue
// flag for grey pixels, saturation and lightness on a 0..65535 scale, and
// alpha copied through.
// Throughput: one item per clock while the skid register is empty.
// Pipeline: 19 register stages (max/min stage, numerator stage, 16 divider
// stages of one quotient bit each, hue offset stage); the first loads at the
// edge that accepts its item.
// Hue and saturation share the same pipelined restoring divider structure,
// one instance each; lightness needs no divider.
// A two-entry output (final stage plus skid register) lets the pipeline still
// advance as the receiver stalls, the stalled result moving into the skid
// register; while the skid register is full i_pix.ready is low and the whole
// pipeline holds, losing nothing. i_pix.ready is driven from a register only.
// Reset clears all valid bits; the block takes items in the first cycle
// after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_convert (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_pix_if.sink    i_pix,
    rhc_hsl_if.source  o_hsl
);
    import rhc_pkg::*;

    localparam int LAST = N_STAGES - 1;

    logic            en;
    logic            r_v [N_STAGES];

    // stage a
    logic [CHAN_W-1:0] r_a_c;
    logic [CHAN_W:0]   r_a_sum;
    logic [CHAN_W-1:0] r_a_mag;
    logic              r_a_neg;
    t_sector           r_a_sector;
    logic [CHAN_W-1:0] r_a_alpha;

    // stage b
    logic [NUM_W-1:0]  r_b_hnum;
    logic [NUM_W-1:0]  r_b_snum;
    logic [DEN_W-1:0]  r_b_hden;
    logic [DEN_W-1:0]  r_b_sden;
    t_side             r_b_side;

    t_side             r_side [DIV_STEPS];
    logic [QUO_W-1:0]  hquo;
    logic [QUO_W-1:0]  squo;

    t_result           r_c;
    t_result           r_k;
    logic              r_k_v;
    t_result           out_res;

    assign en = !r_k_v;
    assign i_pix.ready = en;

    // stage a: max, min, sector and hue difference
    logic [CHAN_W-1:0] hi, lo, dx, dy;
    t_sector           sector;

    always_comb begin
        hi = (i_pix.red_in > i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in > hi) begin
            hi = i_pix.blue_in;
        end
        lo = (i_pix.red_in < i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in < lo) begin
            lo = i_pix.blue_in;
        end
        priority if (hi == i_pix.red_in) begin
            sector = SEC_RED;
            dx     = i_pix.green_in;
            dy     = i_pix.blue_in;
        end else if (hi == i_pix.green_in) begin
            sector = SEC_GREEN;
            dx     = i_pix.blue_in;
            dy     = i_pix.red_in;
        end else begin
            sector = SEC_BLUE;
            dx     = i_pix.red_in;
            dy     = i_pix.green_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_c      <= hi - lo;
            r_a_sum    <= {1'b0, hi} + {1'b0, lo};
            r_a_mag    <= (dx >= dy) ? dx - dy : dy - dx;
            r_a_neg    <= dx < dy;
            r_a_sector <= sector;
            r_a_alpha  <= i_pix.alpha_in;
        end
    end

    // stage b: numerators, divisors and lightness
    logic              grey;
    logic [CHAN_W+8:0] lig_x;
    logic [DEN_W-1:0]  sden;

    always_comb begin
        grey  = r_a_c == '0;
        lig_x = {r_a_sum, 8'd0} + {8'd0, r_a_sum};
        if (r_a_sum <= (CHAN_W+1)'(255)) begin
            sden = r_a_sum[DEN_W-1:0];
        end else begin
            sden = DEN_W'((CHAN_W+1)'(510) - r_a_sum);
        end
        if (grey) begin
            sden = DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_hnum        <= NUM_W'(HUE_SIXTH) * NUM_W'(r_a_mag);
            r_b_snum        <= (NUM_W'(r_a_c) << QUO_W) - NUM_W'(r_a_c);
            r_b_hden        <= grey ? DEN_W'(1) : r_a_c;
            r_b_sden        <= sden;
            r_b_side.sector <= r_a_sector;
            r_b_side.neg    <= r_a_neg;
            r_b_side.grey   <= grey;
            r_b_side.lig    <= lig_x[CHAN_W+8:1];
            r_b_side.alpha  <= r_a_alpha;
        end
    end

    rhc_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_b_hnum),
        .i_den (r_b_hden),
        .o_quo (hquo)
    );

    rhc_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_b_snum),
        .i_den (r_b_sden),
        .o_quo (squo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_b_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stage c: hue offset per sector
    t_side            sd;
    logic [HUE_W-1:0] q;
    logic [HUE_W-1:0] hue;

    always_comb begin
        sd = r_side[DIV_STEPS-1];
        q  = HUE_W'(hquo[HUE_Q_W-1:0]);
        unique case (sd.sector)
            SEC_RED: begin
                if (sd.neg && q != '0) begin
                    hue = HUE_W'(HUE_FULL) - q;
                end else begin
                    hue = sd.neg ? '0 : q;
                end
            end
            SEC_GREEN: hue = sd.neg ? HUE_W'(2*HUE_SIXTH) - q : HUE_W'(2*HUE_SIXTH) + q;
            SEC_BLUE:  hue = sd.neg ? HUE_W'(4*HUE_SIXTH) - q : HUE_W'(4*HUE_SIXTH) + q;
            default:   hue = '0;
        endcase
        if (sd.grey) begin
            hue = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c.hue   <= hue;
            r_c.undef <= sd.grey;
            r_c.sat   <= sd.grey ? '0 : squo;
            r_c.lig   <= sd.lig;
            r_c.alpha <= sd.alpha;
        end
    end

    // valid bits and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
            r_k_v <= 1'b0;
        end else begin
            if (en) begin
                r_v[0] <= i_pix.valid;
                for (int k = 1; k < N_STAGES; k++) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en && r_v[LAST] && !o_hsl.ready) begin
                r_k_v <= 1'b1;
            end else if (r_k_v && o_hsl.ready) begin
                r_k_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v[LAST] && !o_hsl.ready) begin
            r_k <= r_c;
        end
    end

    assign out_res              = r_k_v ? r_k : r_c;
    assign o_hsl.valid          = r_k_v || r_v[LAST];
    assign o_hsl.hue_out        = out_res.hue;
    assign o_hsl.hue_unset      = out_res.undef;
    assign o_hsl.saturation_out = out_res.sat;
    assign o_hsl.lightness_out  = out_res.lig;
    assign o_hsl.alpha_out      = out_res.alpha;

endmodule

`default_nettype wire

[rtl/rhc_div.sv]
// ----------------------------------------------------------------------------
// rhc_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rhc_pkg::NUM_W-1:0]  i_num,
    input  logic [rhc_pkg::DEN_W-1:0]  i_den,
    output logic [rhc_pkg::QUO_W-1:0]  o_quo
);
    import rhc_pkg::*;

    // word holds {partial remainder, remaining numerator bits / quotient bits}
    logic [NUM_W-1:0] r_w   [DIV_STEPS];
    logic [DEN_W-1:0] r_den [DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [NUM_W-1:0] w_src;
        logic [DEN_W-1:0] d_src;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [NUM_W-1:0] n_w;

        if (k == 0) begin : g_first
            assign w_src = i_num;
            assign d_src = i_den;
        end else begin : g_next
            assign w_src = r_w[k-1];
            assign d_src = r_den[k-1];
        end

        assign trial = w_src[NUM_W-1 -: DEN_W+1];
        assign diff  = trial - {1'b0, d_src};

        always_comb begin
            if (trial >= {1'b0, d_src}) begin
                n_w = {diff[DEN_W-1:0], w_src[QUO_W-2:0], 1'b1};
            end else begin
                n_w = {trial[DEN_W-1:0], w_src[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[k] <= n_w;
            end
        end

        if (k < DIV_STEPS-1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= d_src;
                end
            end
        end
    end

    assign o_quo = r_w[DIV_STEPS-1][QUO_W-1:0];

endmodule

`default_nettype wire

[rtl/rhc_check.sv]
// ----------------------------------------------------------------------------
// rhc_check
// port-level checks of the rgb to hsl converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [rhc_pkg::HUE_W-1:0]   i_hue,
    input  logic                        i_undef,
    input  logic [rhc_pkg::UNIT_W-1:0]  i_sat,
    input  logic [rhc_pkg::UNIT_W-1:0]  i_lig
);
    import rhc_pkg::*;

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hue) && $stable(i_undef) && $stable(i_sat)
            && $stable(i_lig))
        else $error("stalled result changed");

    // a stalled input side is ready again in the cycle after the receiver takes the item
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && i_out_ready |=> i_in_ready)
        else $error("input stalled although the result was taken");

    // grey pixel gives zero hue and saturation
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_undef |-> i_hue == '0 && i_sat == '0)
        else $error("grey pixel with non-zero hue or saturation");

    // hue stays below a full turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hue < HUE_W'(HUE_FULL))
        else $error("hue out of range");

endmodule

bind rgb_to_hsl_convert rhc_check u_rhc_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsl.valid),
    .i_out_ready (o_hsl.ready),
    .i_hue       (o_hsl.hue_out),
    .i_undef     (o_hsl.hue_unset),
    .i_sat       (o_hsl.saturation_out),
    .i_lig       (o_hsl.lightness_out)
);

`default_nettype wire
